### design/bafb_pkg.sv
// bafb_pkg: shared types and constants of the block allocator
`timescale 1ns / 1ps

package bafb_pkg;

    localparam int BLOCKS = 16;
    localparam int IDX_W  = $clog2(BLOCKS);
    localparam int CNT_W  = $clog2(BLOCKS + 1);
    localparam int SIZE_W = 16;
    localparam int OWN_W  = 8;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_FIRST = 2'd1,
        KIND_BEST  = 2'd2,
        KIND_FREE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_ALLOC  = 2'd0,
        STAT_NOFIT  = 2'd1,
        STAT_LOADED = 2'd2,
        STAT_FREED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // requests from the sequencer into the block store
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              size_we;
        logic [IDX_W-1:0]  size_addr;
        logic [SIZE_W-1:0] size_wdata;
        logic              claim_we;
        logic [IDX_W-1:0]  claim_addr;
        logic [OWN_W-1:0]  claim_owner;
        logic              release_we;
        logic [IDX_W-1:0]  release_addr;
    } store_req_t;

    // registered read data, available in the cycle after rd_en
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [OWN_W-1:0]  owner;
        logic              taken;
    } store_rsp_t;

endpackage

### design/bafb_store.sv
// bafb_store: block size and owner memories plus taken flags
`timescale 1ns / 1ps

module bafb_store
(
    input  logic                clk,
    input  logic                rst_n,
    input  bafb_pkg::store_req_t req,
    output bafb_pkg::store_rsp_t rsp
);
    import bafb_pkg::*;

    logic [SIZE_W-1:0] size_mem  [BLOCKS];
    logic [OWN_W-1:0]  owner_mem [BLOCKS];
    logic [BLOCKS-1:0] taken_reg;
    store_rsp_t        rsp_reg;

    // taken flags reset to free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else
        begin
            if (req.claim_we)
            begin
                taken_reg[req.claim_addr] <= 1'b1;
            end
            if (req.release_we)
            begin
                taken_reg[req.release_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.size_we)
        begin
            size_mem[req.size_addr] <= req.size_wdata;
        end
        if (req.claim_we)
        begin
            owner_mem[req.claim_addr] <= req.claim_owner;
        end
        if (req.rd_en)
        begin
            rsp_reg.size  <= size_mem[req.rd_addr];
            rsp_reg.owner <= owner_mem[req.rd_addr];
            rsp_reg.taken <= taken_reg[req.rd_addr];
        end
    end

    assign rsp = rsp_reg;

endmodule

### design/block_allocator_first_best_fit.sv
// block_allocator_first_best_fit: fixed-partition allocator top level
`timescale 1ns / 1ps

// usage
// - input beats arrive on s_*; s_tuser carries the request kind (load size,
//   first-fit allocate, best-fit allocate, free owner)
// - every input beat gives exactly one result beat on m_*: a status in
//   m_tuser, claimed block index and released count in m_tdata
// - the user writes blocks_in_use (cfg_wr_en / cfg_wr_data) only while
//   idle, unenforced; values above the table size act as the full table
// - a load goes from accept straight to the finish step; an
//   allocate scans the blocks in use one table entry per cycle through the
//   size memory read port before its finish step; a free scans the whole
//   table the same way; the finish step loads the result into the output
//   register, which then drives the result beat valid
// - one item is in work at a time: s_tready is high only while idle, but
//   the next item is taken while a finished result still sits in the
//   output register
// - if the receiver stalls, the finished item waits in its last step until
//   the output register frees up; nothing is dropped
// - reset clears the taken flags, the register and the output valid;
//   block sizes are unknown until loaded, no clearing pass is run
module block_allocator_first_best_fit
(
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // blocks_in_use
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // load_index[3:0], load_size[19:4],
                                       // request_size[35:20], owner_id[43:36]
    input  logic [1:0]  s_tuser,       // kind[1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // block_index[3:0], freed_count[8:4]
    output logic [1:0]  m_tuser        // status[1:0]
);
    import bafb_pkg::*;

    // registers
    state_t            state_reg,     state_next;
    logic [4:0]        biu_reg;
    kind_t             kind_reg,      kind_next;
    logic [SIZE_W-1:0] request_reg,   request_next;
    logic [OWN_W-1:0]  owner_reg,     owner_next;
    logic [CNT_W-1:0]  limit_reg,     limit_next;
    logic [CNT_W-1:0]  issue_reg,     issue_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  cmp_idx_reg,   cmp_idx_next;
    logic              found_reg,     found_next;
    logic [IDX_W-1:0]  pick_reg,      pick_next;
    logic [SIZE_W-1:0] best_reg,      best_next;
    logic [CNT_W-1:0]  freed_reg,     freed_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    logic [CNT_W-1:0]  out_freed_reg, out_freed_next;

    store_req_t        st_req;
    store_rsp_t        st_rsp;

    logic              in_beat;
    logic              out_free;
    logic              scan_done;
    logic              finish_go;
    logic              alloc_kind;
    logic              fits;
    logic [CNT_W-1:0]  active_n;

    // input field views
    logic [IDX_W-1:0]  in_load_index;
    logic [SIZE_W-1:0] in_load_size;
    logic [SIZE_W-1:0] in_request_size;
    logic [OWN_W-1:0]  in_owner_id;

    assign in_load_index   = s_tdata[3:0];
    assign in_load_size    = s_tdata[19:4];
    assign in_request_size = s_tdata[35:20];
    assign in_owner_id     = s_tdata[43:36];

    assign in_beat    = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign scan_done  = (issue_reg == limit_reg) && !cmp_valid_reg;
    assign finish_go  = (state_reg == ST_FINISH) && out_free;
    assign alloc_kind = (kind_reg == KIND_FIRST) || (kind_reg == KIND_BEST);

    // blocks in use saturate at the table size
    assign active_n = (biu_reg > CNT_W'(BLOCKS)) ? CNT_W'(BLOCKS) : biu_reg[CNT_W-1:0];

    bafb_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (st_req),
        .rsp   (st_rsp)
    );

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = (kind_t'(s_tuser) == KIND_LOAD) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake and store requests
    always_comb
    begin
        s_tready           = (state_reg == ST_IDLE);
        st_req             = '0;
        st_req.rd_en       = (state_reg == ST_SCAN) && (issue_reg != limit_reg);
        st_req.rd_addr     = issue_reg[IDX_W-1:0];
        st_req.size_we     = in_beat && (kind_t'(s_tuser) == KIND_LOAD);
        st_req.size_addr   = in_load_index;
        st_req.size_wdata  = in_load_size;
        st_req.claim_we    = finish_go && alloc_kind && found_reg;
        st_req.claim_addr  = pick_reg;
        st_req.claim_owner = owner_reg;
        st_req.release_we  = cmp_valid_reg && (kind_reg == KIND_FREE)
                             && st_rsp.taken && (st_rsp.owner == owner_reg);
        st_req.release_addr = cmp_idx_reg;
    end

    assign fits = !st_rsp.taken && (st_rsp.size >= request_reg);

    // scan datapath
    always_comb
    begin
        kind_next       = kind_reg;
        request_next    = request_reg;
        owner_next      = owner_reg;
        limit_next      = limit_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        best_next       = best_reg;
        freed_next      = freed_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_freed_next  = out_freed_reg;

        if (in_beat)
        begin
            kind_next    = kind_t'(s_tuser);
            request_next = in_request_size;
            owner_next   = in_owner_id;
            issue_next   = '0;
            found_next   = 1'b0;
            pick_next    = '0;
            best_next    = '0;
            freed_next   = '0;
            case (kind_t'(s_tuser))
                KIND_FIRST, KIND_BEST: limit_next = active_n;
                KIND_FREE:             limit_next = CNT_W'(BLOCKS);
                default:               limit_next = '0;
            endcase
        end

        // read issue, one entry per cycle
        if (st_req.rd_en)
        begin
            issue_next     = issue_reg + CNT_W'(1);
            cmp_valid_next = 1'b1;
            cmp_idx_next   = issue_reg[IDX_W-1:0];
        end

        // compare stage on registered read data
        if (cmp_valid_reg)
        begin
            case (kind_reg)
                KIND_FIRST:
                begin
                    if (fits && !found_reg)
                    begin
                        found_next = 1'b1;
                        pick_next  = cmp_idx_reg;
                    end
                end
                KIND_BEST:
                begin
                    // ties go to the later index
                    if (fits && (!found_reg || st_rsp.size <= best_reg))
                    begin
                        found_next = 1'b1;
                        pick_next  = cmp_idx_reg;
                        best_next  = st_rsp.size;
                    end
                end
                KIND_FREE:
                begin
                    if (st_req.release_we)
                    begin
                        freed_next = freed_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (finish_go)
        begin
            out_valid_next = 1'b1;
            out_index_next = '0;
            out_freed_next = '0;
            case (kind_reg)
                KIND_LOAD:
                begin
                    out_status_next = STAT_LOADED;
                end
                KIND_FREE:
                begin
                    out_status_next = STAT_FREED;
                    out_freed_next  = freed_reg;
                end
                default:
                begin
                    if (found_reg)
                    begin
                        out_status_next = STAT_ALLOC;
                        out_index_next  = pick_reg;
                    end
                    else
                    begin
                        out_status_next = STAT_NOFIT;
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            biu_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                biu_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        request_reg    <= request_next;
        owner_reg      <= owner_next;
        limit_reg      <= limit_next;
        issue_reg      <= issue_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        best_reg       <= best_next;
        freed_reg      <= freed_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_freed_reg  <= out_freed_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_freed_reg, out_index_reg};

`ifndef ASSERT_OFF
    // an accepted beat always moves the sequencer out of idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg != ST_IDLE))
        else $error("input accepted but sequencer stayed idle");

    // results are loaded only from the finish step
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && !m_tready)) |-> (state_reg == ST_FINISH))
        else $error("result loaded outside finish step");

    // only a claim reports a block index
    a_index_only_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != STAT_ALLOC)) |-> (m_tdata[3:0] == 4'd0))
        else $error("block index set without a claim");

    // only a free reports a count, never above the table size
    a_freed_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (((m_tuser != STAT_FREED) && (m_tdata[8:4] == 5'd0))
                      || ((m_tuser == STAT_FREED) && (m_tdata[8:4] <= 5'(BLOCKS)))))
        else $error("freed count out of place or out of range");
`endif

endmodule
